### rtl/lr_pkg.sv
// ---------------------------------------------------------------------------
// lr_pkg: shared types and constants
// Action codes and the attribute width constant.
// ---------------------------------------------------------------------------
package lr_pkg;

  localparam int ATTR_BITS = 16;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

endpackage

### rtl/lr_if.sv
// ---------------------------------------------------------------------------
// lr_if: valid/ready channel interfaces
// Input endpoint beat and output pixel beat.
// ---------------------------------------------------------------------------
interface lr_in_if #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic        [DEPTH_BITS-1:0] z_start;
  logic signed [15:0]           attr_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic        [DEPTH_BITS-1:0] z_end;
  logic signed [15:0]           attr_end;
  modport source (output valid, action, x_start, y_start, z_start, attr_start,
                  x_end, y_end, z_end, attr_end, input ready);
  modport sink   (input valid, action, x_start, y_start, z_start, attr_start,
                  x_end, y_end, z_end, attr_end, output ready);
endinterface

interface lr_out_if #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic        [DEPTH_BITS-1:0] out_z;
  logic signed [15:0]           out_attr;
  logic                         last;
  modport source (output valid, out_x, out_y, out_z, out_attr, last, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_attr, last, output ready);
endinterface

### rtl/lr_front.sv
// ---------------------------------------------------------------------------
// lr_front: segment setup and bresenham walker
// Classifies beats, runs the error-term recurrence, pushes pixel jobs.
// ---------------------------------------------------------------------------
module lr_front #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  lr_in_if.sink in_ch,
  // job push toward the queue
  output logic                         job_valid,
  input  logic                         job_ready,
  output logic signed [COORD_BITS-1:0] job_x,
  output logic signed [COORD_BITS-1:0] job_y,
  output logic        [COORD_BITS:0]   job_k,
  output logic        [COORD_BITS:0]   job_d,
  output logic        [DEPTH_BITS-1:0] job_z0,
  output logic        [DEPTH_BITS-1:0] job_z1,
  output logic signed [15:0]           job_a0,
  output logic signed [15:0]           job_a1,
  output logic                         job_last
);
  import lr_pkg::*;

  localparam int PB = COORD_BITS + 1;
  localparam int EB = COORD_BITS + 3;

  logic                 busy_r;
  logic signed [PB-1:0] maj_r, min_r;
  logic signed [EB-1:0] err_r;
  logic        [PB-1:0] cnt_r, dmaj_r, dmin_r;
  logic                 swap_r, mir_r;
  logic [DEPTH_BITS-1:0] z0_r, z1_r;
  logic signed [15:0]    a0_r, a1_r;

  logic sw;
  logic signed [PB-1:0] x0, y0, x1, y1, ym0, ym1, dx, dy, nmaj, nmin;
  logic signed [EB-1:0] nerr;
  logic [PB-1:0] ncnt;
  logic signed [PB-1:0] px, py;
  logic fire, is_load;

  assign is_load = (in_ch.action == ACT_LOAD);
  // a step while idle is consumed without a job
  assign in_ch.ready = job_ready;
  assign fire = in_ch.valid && in_ch.ready;

  always_comb begin
    sw = in_ch.x_start > in_ch.x_end;
    x0 = PB'(sw ? in_ch.x_end : in_ch.x_start);
    y0 = PB'(sw ? in_ch.y_end : in_ch.y_start);
    x1 = PB'(sw ? in_ch.x_start : in_ch.x_end);
    y1 = PB'(sw ? in_ch.y_start : in_ch.y_end);
    ym0 = (y0 > y1) ? -y0 : y0;
    ym1 = (y0 > y1) ? -y1 : y1;
    dx = x1 - x0;
    dy = ym1 - ym0;
    nmin = min_r;
    nerr = err_r;
    if (err_r > 0) begin
      nmin = min_r + PB'(1);
      nerr = err_r - EB'({dmaj_r, 1'b0});
    end
    nerr = nerr + EB'({dmin_r, 1'b0});
    nmaj = maj_r + PB'(1);
    ncnt = cnt_r + PB'(1);
    px = swap_r ? nmin : nmaj;
    py = swap_r ? nmaj : nmin;
    if (mir_r) py = -py;
  end

  always_comb begin
    job_valid = in_ch.valid && (is_load || busy_r);
    job_z0 = is_load ? (sw ? in_ch.z_end : in_ch.z_start) : z0_r;
    job_z1 = is_load ? (sw ? in_ch.z_start : in_ch.z_end) : z1_r;
    job_a0 = is_load ? (sw ? in_ch.attr_end : in_ch.attr_start) : a0_r;
    job_a1 = is_load ? (sw ? in_ch.attr_start : in_ch.attr_end) : a1_r;
    if (is_load) begin
      job_x = COORD_BITS'(x0);
      job_y = COORD_BITS'(y0);
      job_k = '0;
      job_d = '0;
      job_last = ((dy > dx) ? dy : dx) == 0;
    end else begin
      job_x = COORD_BITS'(px);
      job_y = COORD_BITS'(py);
      job_k = ncnt;
      job_d = dmaj_r;
      job_last = ncnt >= dmaj_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (fire) begin
      if (is_load) begin
        busy_r <= ((dy > dx) ? dy : dx) != 0;
        swap_r <= dy > dx;
        mir_r  <= y0 > y1;
        dmaj_r <= (dy > dx) ? dy : dx;
        dmin_r <= (dy > dx) ? dx : dy;
        maj_r  <= (dy > dx) ? ym0 : x0;
        min_r  <= (dy > dx) ? x0 : ym0;
        err_r  <= (dy > dx) ? (EB'({dx, 1'b0}) - EB'(dy)) : (EB'({dy, 1'b0}) - EB'(dx));
        cnt_r  <= '0;
        z0_r <= job_z0; z1_r <= job_z1; a0_r <= job_a0; a1_r <= job_a1;
      end else if (busy_r) begin
        maj_r <= nmaj; min_r <= nmin; err_r <= nerr; cnt_r <= ncnt;
        if (ncnt >= dmaj_r) busy_r <= 1'b0;
      end
    end
  end
endmodule

### rtl/lr_fifo.sv
// ---------------------------------------------------------------------------
// lr_fifo: small job queue
// Decouples the walker from the interpolator.
// ---------------------------------------------------------------------------
module lr_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0] mem_r [DEPTH];
  logic [AB-1:0] wp_r, rp_r;
  logic [AB:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != (AB+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) begin
        mem_r[wp_r] <= wr_data;
        wp_r <= (wp_r == AB'(DEPTH-1)) ? '0 : wp_r + AB'(1);
      end
      if (rd) rp_r <= (rp_r == AB'(DEPTH-1)) ? '0 : rp_r + AB'(1);
      cnt_r <= cnt_r + (AB+1)'(wr) - (AB+1)'(rd);
    end
  end
endmodule

### rtl/lr_div.sv
// ---------------------------------------------------------------------------
// lr_div: interpolation back end
// Multiplies (end - start) by k, then a restoring divide, one bit a cycle.
// ---------------------------------------------------------------------------
module lr_div #(
  parameter int COORD_BITS = 12,
  parameter int VB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [VB-1:0] a,
  input  logic signed [VB-1:0] b,
  input  logic [COORD_BITS:0]  k,
  input  logic [COORD_BITS:0]  d,
  output logic                 done,
  output logic signed [VB-1:0] res
);
  localparam int NB = VB + COORD_BITS + 2;
  localparam int CB = $clog2(NB + 2);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_MUL = 3'b010, S_DIV = 3'b100
  } dst_t;

  dst_t st_r;
  logic signed [VB:0] diff_r;
  logic [COORD_BITS:0] k_r, d_r;
  logic neg_r;
  logic [NB-1:0] q_r;
  logic [COORD_BITS+1:0] rem_r;
  logic [CB-1:0] n_r;
  logic signed [VB-1:0] a_r;
  logic signed [NB-1:0] prod;
  logic [COORD_BITS+1:0] trial;

  assign prod = NB'(diff_r) * $signed({1'b0, k_r});
  assign trial = {rem_r[COORD_BITS:0], q_r[NB-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st_r)
        S_IDLE: if (start) begin
          diff_r <= (VB+1)'(b) - (VB+1)'(a);
          a_r <= a; k_r <= k; d_r <= d;
          if (d == '0) begin
            res <= a; done <= 1'b1;
          end else st_r <= S_MUL;
        end
        S_MUL: begin
          neg_r <= prod[NB-1];
          q_r <= prod[NB-1] ? -prod : prod;
          rem_r <= '0;
          n_r <= CB'(NB);
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (n_r == '0) begin
            res <= a_r + VB'(neg_r ? -q_r : q_r);
            done <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            if (trial >= (COORD_BITS+2)'(d_r)) begin
              rem_r <= trial - (COORD_BITS+2)'(d_r);
              q_r <= {q_r[NB-2:0], 1'b1};
            end else begin
              rem_r <= trial;
              q_r <= {q_r[NB-2:0], 1'b0};
            end
            n_r <= n_r - CB'(1);
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/line_rasterizer.sv
// ---------------------------------------------------------------------------
// line_rasterizer: bresenham line with depth and attribute interpolation
// Walker front end, job queue, serial divide back end, registered output.
// ---------------------------------------------------------------------------
// a load beat's start pixel passes the queue and the dividers, which skip the
//   divide; a step beat's pixel goes through the multiply, then one quotient bit a cycle
// the back end pops the next job only after the bit-serial interpolation divide
//   is done and the held output pixel has been accepted
// reset: synchronous active-low rst_n clears walker, queue and output valid
module line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input logic clk,
  input logic rst_n,
  lr_in_if.sink    in_ch,
  lr_out_if.source out_ch
);
  import lr_pkg::*;

  localparam int JW = 2*COORD_BITS + 2*(COORD_BITS+1) + 2*DEPTH_BITS + 2*ATTR_BITS + 1;
  localparam int VB = (DEPTH_BITS + 1 > ATTR_BITS) ? DEPTH_BITS + 1 : ATTR_BITS;

  logic                         jv, jr;
  logic signed [COORD_BITS-1:0] jx, jy;
  logic        [COORD_BITS:0]   jk, jd;
  logic        [DEPTH_BITS-1:0] jz0, jz1;
  logic signed [15:0]           ja0, ja1;
  logic                         jl;

  // front end: classify beats and walk the segment
  lr_front #(.COORD_BITS(COORD_BITS), .DEPTH_BITS(DEPTH_BITS)) u_front (
    .clk, .rst_n, .in_ch,
    .job_valid(jv), .job_ready(jr), .job_x(jx), .job_y(jy), .job_k(jk),
    .job_d(jd), .job_z0(jz0), .job_z1(jz1), .job_a0(ja0), .job_a1(ja1),
    .job_last(jl)
  );

  logic [JW-1:0] qd;
  logic          qv, qr;

  // queue of pixel jobs between walker and interpolator
  lr_fifo #(.W(JW), .DEPTH(4)) u_q (
    .clk, .rst_n, .wr_valid(jv), .wr_ready(jr),
    .wr_data({jx, jy, jk, jd, jz0, jz1, ja0, ja1, jl}),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qd)
  );

  logic signed [COORD_BITS-1:0] qx, qy;
  logic        [COORD_BITS:0]   qk, qdd;
  logic        [DEPTH_BITS-1:0] qz0, qz1;
  logic signed [15:0]           qa0, qa1;
  logic                         ql;
  assign {qx, qy, qk, qdd, qz0, qz1, qa0, qa1, ql} = qd;

  // back end sequencing: pop a job, run both divides, hold the pixel
  logic              run_r, go;
  logic              zdone, adone;
  logic signed [VB-1:0] zres, ares;

  assign go = qv && !run_r && !out_ch.valid;
  assign qr = go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (go) begin
        run_r <= 1'b1;
        out_ch.out_x <= qx;
        out_ch.out_y <= qy;
        out_ch.last  <= ql;
      end
      // both dividers share the job, so they finish together
      if (run_r && zdone && adone) begin
        run_r <= 1'b0;
        out_ch.valid <= 1'b1;
        out_ch.out_z <= DEPTH_BITS'(zres);
        out_ch.out_attr <= 16'(ares);
      end
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  lr_div #(.COORD_BITS(COORD_BITS), .VB(VB)) u_zdiv (
    .clk, .rst_n, .start(go),
    .a(VB'({1'b0, qz0})), .b(VB'({1'b0, qz1})), .k(qk), .d(qdd),
    .done(zdone), .res(zres)
  );

  lr_div #(.COORD_BITS(COORD_BITS), .VB(VB)) u_adiv (
    .clk, .rst_n, .start(go),
    .a(VB'(qa0)), .b(VB'(qa1)), .k(qk), .d(qdd),
    .done(adone), .res(ares)
  );
endmodule

### rtl/line_rasterizer_checker.sv
// ---------------------------------------------------------------------------
// line_rasterizer_checker: port-level assertions
// Checks the output beat handshake and reset behavior.
// ---------------------------------------------------------------------------
module line_rasterizer_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
  a_rdy: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last))
    else $error("stalled output beat dropped");
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("back end produced pixels too fast");
endmodule

bind line_rasterizer line_rasterizer_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last)
);

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: line rasterizer testbench
// Drives load and step beats through the valid/ready input channel, predicts
// every pixel with a behavioral Bresenham walk plus exact interpolation, and
// checks each output beat against the oldest expected pixel.
// ---------------------------------------------------------------------------
module tb_top;
  import lr_pkg::*;

  localparam int CB = 12;
  localparam int DB = 16;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic        [DB-1:0] z;
    logic signed [15:0]   a;
    logic                 last;
  } pixel_t;

  typedef struct {
    action_t              act;
    logic signed [CB-1:0] x0, y0;
    logic        [DB-1:0] z0;
    logic signed [15:0]   a0;
    logic signed [CB-1:0] x1, y1;
    logic        [DB-1:0] z1;
    logic signed [15:0]   a1;
    bit                   has_pix;  // typed-in pixel present
    pixel_t               pix;
  } seg_row_t;

  logic clk;
  logic rst_n;

  lr_in_if  #(.COORD_BITS(CB), .DEPTH_BITS(DB)) in_ch ();
  lr_out_if #(.COORD_BITS(CB), .DEPTH_BITS(DB)) out_ch ();

  line_rasterizer #(.COORD_BITS(CB), .DEPTH_BITS(DB)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // walker state mirrored from the block's behavior
  bit          walking;
  int          maj_pos, min_pos, err, steps, maj_span, min_span;
  bit          swapped, mirrored;
  longint      z_lo, z_hi, a_lo, a_hi;

  pixel_t      pixel_q[$];
  int          errors;
  int          pixels_seen;
  int          beats_sent;
  int          send_idle_pct;
  int          recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // generous fixed limit, far beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("timeout at %0t", $time);
    $display("tb_top NOT OK");
    $finish;
  end

  // exact interpolation, quotient truncated toward zero
  function automatic longint interp(longint a, longint b, int k, int d);
    if (d <= 0) begin
      return a;
    end
    return a + ((b - a) * k) / d;
  endfunction

  // advance the walker by one beat; returns 1 when a pixel comes out
  function automatic bit walk_pixel(seg_row_t r, output pixel_t p);
    longint x0, y0, x1, y1, z0, z1, a0, a1, t, dx, dy, bx, by, px, py;
    p = '0;
    if (r.act == ACT_LOAD) begin
      x0 = r.x0; y0 = r.y0; z0 = r.z0; a0 = r.a0;
      x1 = r.x1; y1 = r.y1; z1 = r.z1; a1 = r.a1;
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
        t = z0; z0 = z1; z1 = t;
        t = a0; a0 = a1; a1 = t;
      end
      p.x = x0[CB-1:0]; p.y = y0[CB-1:0]; p.z = z0[DB-1:0]; p.a = a0[15:0];
      z_lo = z0; z_hi = z1; a_lo = a0; a_hi = a1;
      mirrored = (y0 > y1);
      if (mirrored) begin
        y0 = -y0; y1 = -y1;
      end
      dx = x1 - x0; dy = y1 - y0; bx = x0; by = y0;
      swapped = (dy > dx);
      if (swapped) begin
        t = dx; dx = dy; dy = t;
        t = bx; bx = by; by = t;
      end
      maj_span = int'(dx); min_span = int'(dy);
      maj_pos = int'(bx); min_pos = int'(by);
      err = 2 * min_span - maj_span;
      steps = 0;
      walking = (maj_span > 0);
      p.last = !walking;
      return 1'b1;
    end
    if (!walking) begin
      return 1'b0;
    end
    if (err > 0) begin
      min_pos += 1;
      err -= 2 * maj_span;
    end
    err += 2 * min_span;
    maj_pos += 1;
    steps += 1;
    if (swapped) begin
      px = min_pos; py = maj_pos;
    end else begin
      px = maj_pos; py = min_pos;
    end
    if (mirrored) begin
      py = -py;
    end
    t = interp(z_lo, z_hi, steps, maj_span);
    p.z = t[DB-1:0];
    t = interp(a_lo, a_hi, steps, maj_span);
    p.a = t[15:0];
    p.x = px[CB-1:0]; p.y = py[CB-1:0];
    p.last = (steps >= maj_span);
    if (p.last) begin
      walking = 1'b0;
    end
    return 1'b1;
  endfunction

  // one beat on the input channel, with random sender gaps
  task automatic send_beat(seg_row_t r);
    pixel_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= r.act;
    in_ch.x_start    <= r.x0;
    in_ch.y_start    <= r.y0;
    in_ch.z_start    <= r.z0;
    in_ch.attr_start <= r.a0;
    in_ch.x_end      <= r.x1;
    in_ch.y_end      <= r.y1;
    in_ch.z_end      <= r.z1;
    in_ch.attr_end   <= r.a1;
    do @(posedge clk); while (!in_ch.ready);
    // beat accepted at this edge; predict before anything else moves
    if (walk_pixel(r, p)) begin
      if (r.has_pix && p !== r.pix) begin
        $display("%0t table row disagrees with walker: table %h walker %h",
                 $time, r.pix, p);
        errors++;
      end
      pixel_q = {pixel_q, p};
    end
    beats_sent++;
  endtask

  function automatic seg_row_t load_row(int x0, int y0, int z0, int a0,
                                        int x1, int y1, int z1, int a1);
    seg_row_t r;
    r.act = ACT_LOAD;
    r.x0 = x0[CB-1:0]; r.y0 = y0[CB-1:0]; r.z0 = z0[DB-1:0]; r.a0 = a0[15:0];
    r.x1 = x1[CB-1:0]; r.y1 = y1[CB-1:0]; r.z1 = z1[DB-1:0]; r.a1 = a1[15:0];
    r.has_pix = 1'b0;
    r.pix = '0;
    return r;
  endfunction

  function automatic seg_row_t step_row();
    seg_row_t r;
    r = load_row($urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
    r.act = ACT_STEP;
    return r;
  endfunction

  // receiver: random stalls, compare against oldest expected pixel
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        pixel_t got, want;
        got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_attr,
                out_ch.last};
        pixels_seen++;
        if (pixel_q.size() == 0) begin
          $display("%0t unexpected pixel %h", $time, got);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            $display("%0t pixel mismatch: expected x=%0d y=%0d z=%0d a=%0d l=%0b",
                     $time, want.x, want.y, want.z, want.a, want.last);
            $display("%0t                 actual   x=%0d y=%0d z=%0d a=%0d l=%0b",
                     $time, got.x, got.y, got.z, got.a, got.last);
            errors++;
          end
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // a random segment; mostly short so walks finish, sometimes full range
  function automatic seg_row_t rand_load();
    int x0, y0, x1, y1;
    x0 = $urandom_range(4095) - 2048;
    y0 = $urandom_range(4095) - 2048;
    if ($urandom_range(19) == 0) begin
      x1 = $urandom_range(4095) - 2048;
      y1 = $urandom_range(4095) - 2048;
    end else begin
      x1 = x0 + $urandom_range(24) - 12;
      y1 = y0 + $urandom_range(24) - 12;
      if (x1 > 2047) x1 = 2047;
      if (x1 < -2048) x1 = -2048;
      if (y1 > 2047) y1 = 2047;
      if (y1 < -2048) y1 = -2048;
    end
    return load_row(x0, y0, $urandom, $urandom, x1, y1, $urandom, $urandom);
  endfunction

  initial begin
    seg_row_t table_rows[$];
    seg_row_t r;
    int       n;
    int       phase;
    int       walks;

    errors = 0; pixels_seen = 0; beats_sent = 0; walks = 0;
    send_idle_pct = 9; recv_idle_pct = 50;
    walking = 1'b0; maj_pos = 0; min_pos = 0; err = 0; steps = 0;
    maj_span = 0; min_span = 0; swapped = 0; mirrored = 0;
    z_lo = 0; z_hi = 0; a_lo = 0; a_hi = 0;

    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.action = ACT_STEP;
    in_ch.x_start = '0; in_ch.y_start = '0; in_ch.z_start = '0;
    in_ch.attr_start = '0; in_ch.x_end = '0; in_ch.y_end = '0;
    in_ch.z_end = '0; in_ch.attr_end = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: step while idle after reset gives nothing
    table_rows = {table_rows, step_row()};
    // single point: start pixel only, flagged last
    r = load_row(5, -7, 1234, -99, 5, -7, 4321, 77);
    r.has_pix = 1; r.pix = '{12'sd5, -12'sd7, 16'd1234, -16'sd99, 1'b1};
    table_rows = {table_rows, r};
    table_rows = {table_rows, step_row()};
    // corners of the coordinate range, single points
    r = load_row(-2048, -2048, 0, -32768, -2048, -2048, 65535, 32767);
    r.has_pix = 1; r.pix = '{-12'sd2048, -12'sd2048, 16'd0, -16'sd32768, 1'b1};
    table_rows = {table_rows, r};
    r = load_row(2047, 2047, 65535, 32767, 2047, 2047, 0, 0);
    r.has_pix = 1; r.pix = '{12'sd2047, 12'sd2047, 16'd65535, 16'sd32767, 1'b1};
    table_rows = {table_rows, r};
    // reversed endpoints, falling shallow line
    r = load_row(6, 0, 100, 10, 0, 3, 0, -10);
    r.has_pix = 1; r.pix = '{12'sd0, 12'sd3, 16'd0, -16'sd10, 1'b0};
    table_rows = {table_rows, r};
    for (int i = 0; i < 6; i++) table_rows = {table_rows, step_row()};
    // steep rising with extreme depth and attribute
    table_rows = {table_rows, load_row(0, 0, 0, -32768, 2, 5, 65535, 32767)};
    for (int i = 0; i < 3; i++) table_rows = {table_rows, step_row()};
    // load while busy abandons the walk; steep falling, vertical
    table_rows = {table_rows, load_row(1, 4, 9, 9, 1, -3, 1, -1)};
    for (int i = 0; i < 8; i++) table_rows = {table_rows, step_row()};

    foreach (table_rows[i]) send_beat(table_rows[i]);

    // random part in three idling phases
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 9 : 0;
      n = 0;
      while (n < 420) begin
        r = rand_load();
        send_beat(r); n++; walks++;
        // usually walk to the end and a bit past, sometimes cut short
        for (int k = $urandom_range(3) == 0 ? $urandom_range(6) :
                 $urandom_range(40); k > 0 && n < 420; k--) begin
          send_beat(step_row()); n++;
        end
      end
    end

    // one long falling diagonal at the range corner, extreme interpolation
    send_idle_pct = 0; recv_idle_pct = 0;
    send_beat(load_row(-2048, 2047, 0, 32767, -1748, 1747, 65535, -32768));
    for (int i = 0; i < 305; i++) send_beat(step_row());
    in_ch.valid <= 1'b0;

    fork
      begin
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
      end
      begin
        repeat (2_000_000) @(posedge clk);
        $display("drain limit hit with %0d pixels pending", pixel_q.size());
        errors++;
      end
    join_any
    disable fork;

    $display("covered %0d beats, %0d segments, %0d pixels checked",
             beats_sent, walks + 7, pixels_seen);
    $display("sender and receiver stalls swept over three idling phases");
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
